### design/hmtri_pkg.sv
`default_nettype none

package hmtri_pkg;

  // Fixed field widths of the item channels.
  localparam int unsigned POS_W    = 16;
  localparam int unsigned COORD_W  = 7;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned QUADS_W  = 7;

  // Operation carried by an input item.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Parity bank of the vertex store: {row parity, column parity}.
  typedef logic [1:0] bank_sel_t;

endpackage

`default_nettype wire

### design/heightmap_triangle_height_query.sv
`default_nettype none

// Triangulated heightmap height query. The block holds a square grid of
// signed 16-bit vertex heights, loaded by write items (op = 0), and answers
// query items (op = 1) with the height of the surface at a position of the
// unit square, given as Q0.16 fractions. Each coordinate is scaled by the
// number of quads in use; the integer part picks the cell, the fraction gives
// u and v, and the height is interpolated over the lower-left or upper-right
// triangle of the cell, rounded to nearest with halves going up, and
// saturated to 16 bits. A query gives exactly one result and a write gives
// none. The block takes one item per clock cycle while the output side is
// not stalled; a stalled full pipeline holds the input back. A query passes
// through the scaling, addressing, store read, triangle, product and output
// stages in order. The rate is set by the vertex store, which is split into
// four banks by row and column parity, so the four corners of any cell sit in
// four different banks and are read in the same cycle, one port per bank.
// Writes pass through the same pipeline and update the store in the stage
// where queries read it, so items always see the grid in transfer order.
// The grid comes out of reset undefined: a query must only touch vertices
// that have been written since reset, and there is no clearing pass. The
// quad count register is written over its own channel; the user must write
// it only while the block is idle, which the block itself does not enforce.
// Values of zero act as one and values above MAX_QUADS act as MAX_QUADS.
module heightmap_triangle_height_query
  import hmtri_pkg::*;
#(
  parameter int unsigned MAX_QUADS = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Configuration channel.
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire         [QUADS_W-1:0]        quads_in_use_i,
  // Input item channel.
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              op_i,
  input  wire         [POS_W-1:0]          query_x_i,
  input  wire         [POS_W-1:0]          query_y_i,
  input  wire         [COORD_W-1:0]        vertex_col_i,
  input  wire         [COORD_W-1:0]        vertex_row_i,
  input  wire  signed [HEIGHT_W-1:0]       vertex_height_i,
  // Result channel.
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic signed [HEIGHT_W-1:0]       height_o
);

  // Each bank holds every other row and every other column of the grid.
  localparam int unsigned BSIDE  = (MAX_QUADS + 2) / 2;
  localparam int unsigned BDEPTH = BSIDE * BSIDE;
  localparam int unsigned AW     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  // The register is seven bits wide, so the usable count tops out there.
  localparam int unsigned NCAP   = (MAX_QUADS < 127) ? MAX_QUADS : 127;
  localparam int unsigned NRST   = (MAX_QUADS < 64) ? MAX_QUADS : 64;
  localparam int unsigned SX_W   = POS_W + QUADS_W;
  localparam int unsigned UPSH   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int unsigned DNSH   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int unsigned WW     = FRAC_BITS + 1;
  localparam int unsigned PW     = FRAC_BITS + 18;
  localparam int unsigned SUMW   = PW + 2;
  localparam int          HALF_I = 1 << (FRAC_BITS - 1);
  localparam logic [WW-1:0] ONE_W = {1'b1, {FRAC_BITS{1'b0}}};

  // Quad count, stored already clamped to its legal range.
  logic [QUADS_W-1:0] quads_q, quads_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (quads_in_use_i == '0) begin
      quads_d = QUADS_W'(1);
    end else if (32'(quads_in_use_i) > NCAP) begin
      quads_d = QUADS_W'(NCAP);
    end else begin
      quads_d = quads_in_use_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quads_q <= QUADS_W'(NRST);
    end else if (cfg_valid_i) begin
      quads_q <= quads_d;
    end
  end

  // Stage enables: a stage loads when it is empty or its content moves on.
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !out_valid_o || out_ready_i;
  assign en5 = !s5_valid_q || en6;
  assign en4 = !s4_valid_q || en5;
  assign en3 = !s3_valid_q || en4;
  assign en2 = !s2_valid_q || en3;
  assign en1 = !s1_valid_q || en2;
  assign in_ready_o = en1;

  // Stage 1: scale the position by the quad count.
  logic                       s1_op_q;
  logic        [SX_W-1:0]     s1_sx_q, s1_sy_q;
  logic        [COORD_W-1:0]  s1_col_q, s1_row_q;
  logic signed [HEIGHT_W-1:0] s1_hgt_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_op_q  <= op_i;
      s1_sx_q  <= SX_W'(query_x_i) * SX_W'(quads_q);
      s1_sy_q  <= SX_W'(query_y_i) * SX_W'(quads_q);
      s1_col_q <= vertex_col_i;
      s1_row_q <= vertex_row_i;
      s1_hgt_q <= vertex_height_i;
    end
  end

  // Stage 2: cell, fractions and bank addresses.
  logic [COORD_W-1:0]  cx, cy;
  logic [POS_W-1:0]    fx, fy;
  logic [COORD_W-1:0]  ch [2];
  logic [COORD_W-1:0]  rh [2];
  logic [AW-1:0]       raddr_d [4];

  logic                       s2_op_q;
  logic                       s2_wen_q;
  bank_sel_t                  s2_wbank_q;
  logic        [AW-1:0]       s2_waddr_q;
  logic signed [HEIGHT_W-1:0] s2_wdata_q;
  logic        [AW-1:0]       s2_raddr_q [4];
  logic                       s2_px_q, s2_py_q;
  logic        [FRAC_BITS-1:0] s2_u_q, s2_v_q;

  always_comb begin
    cx = s1_sx_q[SX_W-1:POS_W];
    cy = s1_sy_q[SX_W-1:POS_W];
    fx = s1_sx_q[POS_W-1:0];
    fy = s1_sy_q[POS_W-1:0];
    // Even banks take the even one of c and c+1, odd banks the odd one.
    ch[0] = {1'b0, cx[COORD_W-1:1]} + COORD_W'(cx[0]);
    ch[1] = {1'b0, cx[COORD_W-1:1]};
    rh[0] = {1'b0, cy[COORD_W-1:1]} + COORD_W'(cy[0]);
    rh[1] = {1'b0, cy[COORD_W-1:1]};
    for (int b = 0; b < 4; b++) begin
      raddr_d[b] = AW'(32'(rh[b / 2]) * BSIDE + 32'(ch[b % 2]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_op_q    <= s1_op_q;
      s2_wen_q   <= (s1_op_q == OP_WRITE) && (32'(s1_col_q) <= MAX_QUADS)
                    && (32'(s1_row_q) <= MAX_QUADS);
      s2_wbank_q <= {s1_row_q[0], s1_col_q[0]};
      s2_waddr_q <= AW'(32'(s1_row_q[COORD_W-1:1]) * BSIDE
                        + 32'(s1_col_q[COORD_W-1:1]));
      s2_wdata_q <= s1_hgt_q;
      s2_raddr_q <= raddr_d;
      s2_px_q    <= cx[0];
      s2_py_q    <= cy[0];
      s2_u_q     <= FRAC_BITS'((32'(fx) << UPSH) >> DNSH);
      s2_v_q     <= FRAC_BITS'((32'(fy) << UPSH) >> DNSH);
    end
  end

  // Vertex store: four parity banks, one write and one read port each.
  logic                       store_we;
  logic signed [HEIGHT_W-1:0] bank_rd [4];

  assign store_we = s2_valid_q && s2_wen_q && en3;

  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    logic signed [HEIGHT_W-1:0] mem [BDEPTH];
    logic signed [HEIGHT_W-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (store_we && (s2_wbank_q == bank_sel_t'(gb))) begin
        mem[s2_waddr_q] <= s2_wdata_q;
      end
      if (en3) begin
        rd_q <= mem[s2_raddr_q[gb]];
      end
    end

    assign bank_rd[gb] = rd_q;
  end

  // Stage 3 carries the fractions next to the bank read data.
  logic                 s3_px_q, s3_py_q;
  logic [FRAC_BITS-1:0] s3_u_q, s3_v_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_px_q <= s2_px_q;
      s3_py_q <= s2_py_q;
      s3_u_q  <= s2_u_q;
      s3_v_q  <= s2_v_q;
    end
  end

  // Stage 4: pick the triangle and its weights. SE and NW are corners of
  // both triangles; the third corner is SW below the diagonal, else NE.
  logic signed [HEIGHT_W-1:0] sw, se, nw, ne;
  logic        [WW-1:0]       uv_sum;
  logic                       lower;
  logic        [WW-1:0]       s4_wa_q, s4_wb_q, s4_wc_q;
  logic signed [HEIGHT_W-1:0] s4_ha_q, s4_hb_q, s4_hc_q;

  always_comb begin
    sw     = bank_rd[{s3_py_q, s3_px_q}];
    se     = bank_rd[{s3_py_q, !s3_px_q}];
    nw     = bank_rd[{!s3_py_q, s3_px_q}];
    ne     = bank_rd[{!s3_py_q, !s3_px_q}];
    uv_sum = {1'b0, s3_u_q} + {1'b0, s3_v_q};
    lower  = !uv_sum[FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_wa_q <= lower ? (ONE_W - uv_sum) : (uv_sum - ONE_W);
      s4_wb_q <= lower ? {1'b0, s3_u_q} : (ONE_W - {1'b0, s3_v_q});
      s4_wc_q <= lower ? {1'b0, s3_v_q} : (ONE_W - {1'b0, s3_u_q});
      s4_ha_q <= lower ? sw : ne;
      s4_hb_q <= se;
      s4_hc_q <= nw;
    end
  end

  // Stage 5: one product per corner.
  logic signed [PW-1:0] s5_pa_q, s5_pb_q, s5_pc_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      s5_pa_q <= $signed({1'b0, s4_wa_q}) * s4_ha_q;
      s5_pb_q <= $signed({1'b0, s4_wb_q}) * s4_hb_q;
      s5_pc_q <= $signed({1'b0, s4_wc_q}) * s4_hc_q;
    end
  end

  // Stage 6: sum, round half up, saturate into the output register.
  logic signed [SUMW-1:0]     acc, acc_sh;
  logic signed [HEIGHT_W-1:0] height_d;

  always_comb begin
    acc    = SUMW'(s5_pa_q) + SUMW'(s5_pb_q) + SUMW'(s5_pc_q) + SUMW'(HALF_I);
    acc_sh = acc >>> FRAC_BITS;
    if (acc_sh > SUMW'(32767)) begin
      height_d = 16'sh7fff;
    end else if (acc_sh < -SUMW'(32768)) begin
      height_d = -16'sh8000;
    end else begin
      height_d = HEIGHT_W'(acc_sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      height_o <= height_d;
    end
  end

  // Valid bits travel with the data; writes leave after the store update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_q <= in_valid_i;
      end
      if (en2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (en3) begin
        s3_valid_q <= s2_valid_q && (s2_op_q == OP_QUERY);
      end
      if (en4) begin
        s4_valid_q <= s3_valid_q;
      end
      if (en5) begin
        s5_valid_q <= s4_valid_q;
      end
      if (en6) begin
        out_valid_o <= s5_valid_q;
      end
    end
  end

  // The stored quad count always lies in its legal range.
  a_quads_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (quads_q != '0) && (32'(quads_q) <= MAX_QUADS))
    else $error("quad count register out of range");

  // Input back pressure only ever comes from a stalled full pipeline.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && s1_valid_q && s5_valid_q))
    else $error("input stalled without output back pressure");

  // The three barycentric weights of a live item always sum to one.
  a_weight_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q |-> ((32'(s4_wa_q) + 32'(s4_wb_q) + 32'(s4_wc_q)) == 32'(ONE_W)))
    else $error("interpolation weights do not sum to one");

  // A result only appears after the last pipeline stage held an item.
  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(s5_valid_q))
    else $error("result appeared without a source item");

endmodule

`default_nettype wire
